>>> design/wildcard_byte_pattern_scanner_assert.svh
// Assertion macros for the wildcard byte pattern scanner.
// Used by the top level; needs a clk and an rst_n in scope.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge out of reset
`define WBPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition at one edge, consequence at the next
`define WBPS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define WBPS_ASSERT(lbl, prop, msg)
`define WBPS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> design/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies.
`default_nettype none

package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 128;
    localparam int ADDR_W          = 48;
    localparam int COUNT_W         = 16;
    localparam int LEN_W           = 8;
    localparam int IDX_W           = 7;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int GROUP           = 16;    // hit bits ANDed per reduce group

    // item actions
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_DATA    = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_END       = 1'b1;

    localparam logic [LEN_W-1:0]   LEN_RESET = 8'd1;
    localparam logic [ADDR_W-1:0]  END_RESET = {ADDR_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  entry_index;
        logic [BYTE_W-1:0] entry_value;
        logic              entry_wildcard;
        logic [ADDR_W-1:0] region_start;
        logic [BYTE_W-1:0] data_byte;
    } scan_item_t;

    typedef struct packed {
        logic               match_found;
        logic [ADDR_W-1:0]  match_address;
        logic [COUNT_W-1:0] match_total;
        logic               single_match;
    } scan_result_t;

    typedef struct packed {
        logic              wild;
        logic [BYTE_W-1:0] value;
    } pat_entry_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic       shift;      // accepted data byte enters the window
        logic       rotate;     // pattern row steps one cell toward the end
        pat_entry_t entry;      // pattern entry being loaded
    } cell_ctl_t;

    // travels alongside the hit bits down the pipeline
    typedef struct packed {
        logic              cand;    // in-range data byte with a full window
        logic [ADDR_W-1:0] addr;    // window start address
    } side_t;

endpackage

`default_nettype wire

>>> design/wbps_cell.sv
// One window/pattern cell: holds a window byte, an aligned pattern entry
// and the registered compare result. Uses wbps_pkg.
`default_nettype none

module wbps_cell (
    input  wire logic                        clk,
    input  wire wbps_pkg::cell_ctl_t         ctl,
    input  wire logic                        load_en,
    input  wire logic                        active,
    input  wire logic [wbps_pkg::BYTE_W-1:0] win_in,
    input  wire wbps_pkg::pat_entry_t        pat_in,
    output logic      [wbps_pkg::BYTE_W-1:0] win_out,
    output wbps_pkg::pat_entry_t             pat_out,
    output logic                             hit
);

    logic [wbps_pkg::BYTE_W-1:0] win_reg;
    wbps_pkg::pat_entry_t        pat_reg;
    logic                        hit_reg;
    logic                        hit_next;

    // compare against the byte this cell holds after the shift
    assign hit_next = !active || pat_reg.wild || (win_in == pat_reg.value);

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            win_reg <= win_in;
            hit_reg <= hit_next;
        end
        if (load_en)
        begin
            pat_reg <= ctl.entry;
        end
        else if (ctl.rotate)
        begin
            pat_reg <= pat_in;
        end
    end

    assign win_out = win_reg;
    assign pat_out = pat_reg;
    assign hit     = hit_reg;

endmodule

`default_nettype wire

>>> design/wbps_reduce.sv
// Registered first level of the hit AND tree: one bit per group of cells.
// Uses wbps_pkg.
`default_nettype none

module wbps_reduce #(
    parameter int N = wbps_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [N-1:0]          hits,
    output logic [(N + wbps_pkg::GROUP - 1) / wbps_pkg::GROUP - 1:0] groups
);

    localparam int NG = (N + wbps_pkg::GROUP - 1) / wbps_pkg::GROUP;

    logic [NG-1:0] grp_reg;
    logic [NG-1:0] grp_next;

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        localparam int LO = g * wbps_pkg::GROUP;
        localparam int HI = ((LO + wbps_pkg::GROUP) < N) ? (LO + wbps_pkg::GROUP - 1) : (N - 1);
        assign grp_next[g] = &hits[HI:LO];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg <= grp_next;
        end
    end

    assign groups = grp_reg;

endmodule

`default_nettype wire

>>> design/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: cell row, AND tree,
// counters and handshakes. Uses wbps_pkg, wbps_cell, wbps_reduce.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  item     | item_valid / item_stall  | item   (scan_item_t)
//  result   | result_valid/result_stall| result (scan_result_t)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word per cycle in and one result per cycle out while nothing stalls;
// a result passes the registered stages: cell compare, group AND,
// final AND and count. A pattern_length write realigns the pattern row
// one cell per cycle; item_stall is high and cfg_ready low until it is done.
// result_stall on a held result freezes all stages and raises item_stall.
// Reset presets the control state; pattern entries are undefined until loaded.
`default_nettype none
`include "wildcard_byte_pattern_scanner_assert.svh"

module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire wbps_pkg::scan_item_t           item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output wbps_pkg::scan_result_t              result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wbps_pkg::ADDR_W-1:0]    cfg_data
);

    localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int BW = $clog2(PATTERN_MAX + 1);
    localparam int DW = ((PW > wbps_pkg::IDX_W) ? PW : wbps_pkg::IDX_W) + 1;
    localparam int NG = (PATTERN_MAX + wbps_pkg::GROUP - 1) / wbps_pkg::GROUP;
    localparam logic [8:0]    N_LEN   = 9'(PATTERN_MAX);
    localparam logic [PW-1:0] OFF_MAX = PW'(PATTERN_MAX - 1);
    localparam logic [BW-1:0] BIR_MAX = BW'(PATTERN_MAX);
    localparam logic [DW-1:0] N_D     = DW'(PATTERN_MAX);

    // config and scan state
    logic [wbps_pkg::LEN_W-1:0]   plen_reg;
    logic [wbps_pkg::ADDR_W-1:0]  end_reg;
    logic [PW-1:0]                rot_reg, rot_next;
    logic [wbps_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [BW-1:0]                bir_reg, bir_next;
    logic [wbps_pkg::COUNT_W-1:0] cnt_reg, cnt_next;

    // pipeline
    logic                  s1_vld_reg, s2_vld_reg, out_vld_reg;
    wbps_pkg::side_t       side1_reg, side1_next, side2_reg;
    wbps_pkg::scan_result_t result_reg, result_next;
    logic [NG-1:0]         groups;

    logic       adv, rot_busy, item_acc, cfg_acc;
    logic [8:0] eff_len;
    logic [PW-1:0] off_tgt;
    logic       pass, shift, full, load_go, fin_found;
    logic [BW-1:0] bir_inc;
    logic [DW-1:0] pos_d;
    logic [PW-1:0] wr_pos;
    wbps_pkg::cell_ctl_t ctl;

    // effective length: zero acts as one, clipped at the row length
    always_comb
    begin
        if (plen_reg == '0)
            eff_len = 9'd1;
        else if ({1'b0, plen_reg} > N_LEN)
            eff_len = N_LEN;
        else
            eff_len = {1'b0, plen_reg};
        off_tgt = PW'(eff_len - 9'd1);
    end

    assign rot_busy   = (rot_reg != off_tgt);
    assign adv        = !out_vld_reg || !result_stall;
    assign item_stall = rot_busy || !adv;
    assign item_acc   = item_valid && !item_stall;
    assign cfg_ready  = !rot_busy;
    assign cfg_acc    = cfg_valid && cfg_ready;

    assign pass    = (addr_reg < end_reg);
    assign shift   = item_acc && (item.action == wbps_pkg::ACT_DATA) && pass;
    assign bir_inc = (bir_reg == BIR_MAX) ? bir_reg : bir_reg + 1'b1;
    assign full    = (bir_inc > BW'(rot_reg));

    // cell k holds pattern position (offset - k) mod PATTERN_MAX
    always_comb
    begin
        pos_d = DW'(rot_reg) - DW'(item.entry_index);
        if (pos_d[DW-1])
            pos_d = pos_d + N_D;
        wr_pos = pos_d[PW-1:0];
    end

    assign load_go = item_acc && (item.action == wbps_pkg::ACT_LOAD)
                     && (DW'(item.entry_index) < N_D);

    assign ctl.shift        = shift;
    assign ctl.rotate       = rot_busy;
    assign ctl.entry.wild   = item.entry_wildcard;
    assign ctl.entry.value  = item.entry_value;

    assign rot_next = (rot_reg == OFF_MAX) ? '0 : rot_reg + 1'b1;

    // cell row
    logic [wbps_pkg::BYTE_W-1:0] win   [PATTERN_MAX];
    wbps_pkg::pat_entry_t        pat   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]      hits;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [wbps_pkg::BYTE_W-1:0] w_in;
        wbps_pkg::pat_entry_t        p_in;

        if (k == 0)
        begin : g_head
            assign w_in = item.data_byte;
            assign p_in = pat[PATTERN_MAX-1];
        end
        else
        begin : g_body
            assign w_in = win[k-1];
            assign p_in = pat[k-1];
        end

        wbps_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .load_en (load_go && (wr_pos == PW'(k))),
            .active  (PW'(k) <= rot_reg),
            .win_in  (w_in),
            .pat_in  (p_in),
            .win_out (win[k]),
            .pat_out (pat[k]),
            .hit     (hits[k])
        );
    end

    wbps_reduce #(
        .N (PATTERN_MAX)
    ) u_reduce (
        .clk    (clk),
        .en     (adv),
        .hits   (hits),
        .groups (groups)
    );

    // scan state next values
    always_comb
    begin
        addr_next = addr_reg;
        bir_next  = bir_reg;
        if (item_acc)
        begin
            unique case (item.action)
                wbps_pkg::ACT_RESTART:
                begin
                    addr_next = item.region_start;
                    bir_next  = '0;
                end
                wbps_pkg::ACT_DATA:
                begin
                    if (pass)
                    begin
                        addr_next = addr_reg + 1'b1;
                        bir_next  = bir_inc;
                    end
                end
                default:
                begin
                    addr_next = addr_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        side1_next.cand = shift && full;
        side1_next.addr = (shift && full)
                          ? addr_reg - wbps_pkg::ADDR_W'(rot_reg) : '0;
    end

    // final AND, count and result word
    assign fin_found = side2_reg.cand && (&groups);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (adv && s2_vld_reg && fin_found && (cnt_reg != wbps_pkg::COUNT_MAX))
            cnt_next = cnt_reg + 1'b1;
        result_next.match_found   = fin_found;
        result_next.match_address = fin_found ? side2_reg.addr : '0;
        result_next.match_total   = cnt_next;
        result_next.single_match  = (cnt_next == wbps_pkg::COUNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= wbps_pkg::LEN_RESET;
            end_reg     <= wbps_pkg::END_RESET;
            rot_reg     <= '0;
            addr_reg    <= '0;
            bir_reg     <= '0;
            cnt_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    wbps_pkg::CFG_PATTERN_LENGTH: plen_reg <= cfg_data[wbps_pkg::LEN_W-1:0];
                    wbps_pkg::CFG_SCAN_END:       end_reg  <= cfg_data;
                    default:                      end_reg  <= end_reg;
                endcase
            end
            if (rot_busy)
            begin
                rot_reg <= rot_next;
            end
            addr_reg <= addr_next;
            bir_reg  <= bir_next;
            cnt_reg  <= cnt_next;
            if (adv)
            begin
                s1_vld_reg  <= item_acc;
                s2_vld_reg  <= s1_vld_reg;
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg  <= side1_next;
            side2_reg  <= side1_reg;
            result_reg <= result_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = result_reg;

    `WBPS_ASSERT_NEXT(a_rot_hold, item_acc, $stable(rot_reg), "pattern offset moved under an accepted word")
    `WBPS_ASSERT_NEXT(a_cnt_hold, (!adv || !s2_vld_reg || !fin_found), $stable(cnt_reg), "match count moved without a match")
    `WBPS_ASSERT(a_bir_max, bir_reg <= BIR_MAX, "region byte count past the window depth")
    `WBPS_ASSERT(a_found_cnt, (out_vld_reg && result_reg.match_found) |-> (result_reg.match_total != '0), "match reported with zero count")

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for wildcard_byte_pattern_scanner: directed and random
// words with bursty input and stalled output, checked against an inline predictor.
// Depends on wbps_pkg and the scanner RTL.
module testbench;

    localparam int BYTE_W    = wbps_pkg::BYTE_W;
    localparam int ADDR_W    = wbps_pkg::ADDR_W;
    localparam int LEN_W     = wbps_pkg::LEN_W;
    localparam int COUNT_W   = wbps_pkg::COUNT_W;
    localparam int IDX_W     = wbps_pkg::IDX_W;
    localparam int CFG_IDX_W = wbps_pkg::CFG_IDX_W;
    localparam int PMAX      = wbps_pkg::PATTERN_MAX_DEF;

    localparam logic [1:0] ACT_NONE = 2'd3;     // unused action code
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES = 12;

    typedef enum int {END_OPEN, END_NEAR, END_ZERO, END_RANDOM} end_mode_t;
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_RUNS} stall_mode_t;

    class scan_tracker;
        logic [BYTE_W-1:0]        pat_value [PMAX];
        bit                       pat_wild [PMAX];
        bit                       pat_set [PMAX];
        logic [BYTE_W-1:0]        window [PMAX];   // index 0 is the newest byte
        logic [ADDR_W-1:0]        next_addr;
        int                       fill;
        int unsigned              match_count;
        logic [LEN_W-1:0]         length_reg;
        logic [ADDR_W-1:0]        end_reg;
        wbps_pkg::scan_result_t   awaited[$];
        int                       errors;
        int                       checked;
        int                       found;

        function new();
            foreach (pat_value[i])
            begin
                pat_value[i] = '0;
                pat_wild[i] = 1'b0;
                pat_set[i] = 1'b0;
                window[i] = '0;
            end
            next_addr = '0;
            fill = 0;
            match_count = 0;
            length_reg = wbps_pkg::LEN_RESET;
            end_reg = wbps_pkg::END_RESET;
            errors = 0;
            checked = 0;
            found = 0;
        endfunction

        function int active_length();
            int n;
            n = int'(length_reg);
            if (n < 1) n = 1;
            if (n > PMAX) n = PMAX;
            return n;
        endfunction

        function bit window_hit(input int len);
            for (int i = 0; i < len; i++)
                if (!pat_wild[i] && window[len - 1 - i] != pat_value[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
            if (idx == wbps_pkg::CFG_PATTERN_LENGTH)
                length_reg = data[LEN_W-1:0];
            else
                end_reg = data;
        endfunction

        function void note_item(input wbps_pkg::scan_item_t it);
            wbps_pkg::scan_result_t r;
            int len;
            r = '0;
            case (it.action)
                wbps_pkg::ACT_LOAD:
                begin
                    pat_value[it.entry_index] = it.entry_value;
                    pat_wild[it.entry_index] = it.entry_wildcard;
                    pat_set[it.entry_index] = 1'b1;
                end
                wbps_pkg::ACT_RESTART:
                begin
                    next_addr = it.region_start;
                    fill = 0;
                    foreach (window[i]) window[i] = '0;
                end
                wbps_pkg::ACT_DATA:
                begin
                    // bytes at or past the end address leave everything untouched
                    if (next_addr < end_reg)
                    begin
                        len = active_length();
                        for (int i = PMAX - 1; i > 0; i--) window[i] = window[i - 1];
                        window[0] = it.data_byte;
                        if (fill < PMAX) fill++;
                        if (fill >= len && window_hit(len))
                        begin
                            r.match_found = 1'b1;
                            r.match_address = next_addr - ADDR_W'(len - 1);
                            if (match_count < wbps_pkg::COUNT_MAX) match_count++;
                            found++;
                        end
                        next_addr = next_addr + 1'b1;
                    end
                end
                default: ;
            endcase
            r.match_total = match_count[COUNT_W-1:0];
            r.single_match = (match_count == 1);
            awaited = {awaited, r};
        endfunction

        function void check_result(input wbps_pkg::scan_result_t got);
            wbps_pkg::scan_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing awaited");
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.match_found !== want.match_found)
            begin
                $error("match_found: expected %0d, got %0d", want.match_found, got.match_found);
                errors++;
            end
            if (got.match_address !== want.match_address)
            begin
                $error("match_address: expected %h, got %h",
                       want.match_address, got.match_address);
                errors++;
            end
            if (got.match_total !== want.match_total)
            begin
                $error("match_total: expected %0d, got %0d", want.match_total, got.match_total);
                errors++;
            end
            if (got.single_match !== want.single_match)
            begin
                $error("single_match: expected %0d, got %0d",
                       want.single_match, got.single_match);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_stall;
    wbps_pkg::scan_item_t     item = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    wbps_pkg::scan_result_t   result;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [ADDR_W-1:0]        cfg_data = '0;

    scan_tracker tracker = new();

    int          burst_left = 0;
    int unsigned words_sent = 0;
    int          idle_cycles = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_span = 0;

    wildcard_byte_pattern_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            tracker.check_result(result);

    // receiver stall pattern: picks one of four modes at random and holds it for a random span
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_span = $urandom_range(10, 80);
        end
        else
            stall_span = stall_span - 1;
        case (stall_mode)
            STALL_NONE:   result_stall <= 1'b0;
            STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
            STALL_TOGGLE: result_stall <= !result_stall;
            default:      result_stall <= (stall_span % 5) < 2;
        endcase
    end

    always @(posedge clk)
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // unused fields carry random junk so every bit toggles
    function automatic wbps_pkg::scan_item_t make_word(input logic [1:0] act);
        wbps_pkg::scan_item_t w;
        w.action = act;
        w.entry_index = IDX_W'($urandom_range(0, 127));
        w.entry_value = rand_byte();
        w.entry_wildcard = 1'($urandom_range(0, 1));
        w.region_start = rand_addr();
        w.data_byte = rand_byte();
        return w;
    endfunction

    task automatic send_word(input wbps_pkg::scan_item_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        tracker.note_item(w);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_load(input int idx, input logic [BYTE_W-1:0] val, input bit wild);
        wbps_pkg::scan_item_t w;
        w = make_word(wbps_pkg::ACT_LOAD);
        w.entry_index = IDX_W'(idx);
        w.entry_value = val;
        w.entry_wildcard = wild;
        send_word(w);
    endtask

    task automatic send_restart(input logic [ADDR_W-1:0] addr);
        wbps_pkg::scan_item_t w;
        w = make_word(wbps_pkg::ACT_RESTART);
        w.region_start = addr;
        send_word(w);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        wbps_pkg::scan_item_t w;
        w = make_word(wbps_pkg::ACT_DATA);
        w.data_byte = b;
        send_word(w);
    endtask

    // one full window of the loaded pattern, optionally with one bit flipped
    task automatic send_pattern_copy(input bit spoil);
        int len;
        int bad;
        logic [BYTE_W-1:0] b;
        len = tracker.active_length();
        bad = spoil ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            b = tracker.pat_wild[i] ? rand_byte() : tracker.pat_value[i];
            if (i == bad) b = b ^ (8'd1 << $urandom_range(0, 7));
            send_byte(b);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // registers are only touched with the pipeline empty
    task automatic program_scan(input logic [ADDR_W-1:0] len_word,
                                input logic [ADDR_W-1:0] end_addr);
        settle();
        cfg_index <= wbps_pkg::CFG_PATTERN_LENGTH;
        cfg_data <= len_word;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.note_config(wbps_pkg::CFG_PATTERN_LENGTH, len_word);
        cfg_index <= wbps_pkg::CFG_SCAN_END;
        cfg_data <= end_addr;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.note_config(wbps_pkg::CFG_SCAN_END, end_addr);
        cfg_valid <= 1'b0;
    endtask

    // every position in use gets loaded before any compare can reach it
    task automatic load_fresh_pattern();
        int len;
        len = tracker.active_length();
        if (len <= 32)
        begin
            for (int i = 0; i < len; i++)
                send_load(i, rand_byte(), $urandom_range(0, 3) == 0);
        end
        else
        begin
            for (int i = 0; i < len; i++)
                if (!tracker.pat_set[i])
                    send_load(i, rand_byte(), $urandom_range(0, 3) == 0);
            repeat (4)
                send_load($urandom_range(0, len - 1), rand_byte(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len_val, input end_mode_t mode,
                             input int words);
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] len_word;
        int len;
        int pick;
        int n;
        int k;
        base = rand_addr();
        case (mode)
            END_OPEN: end_addr = wbps_pkg::END_RESET;
            END_NEAR: end_addr = base + ADDR_W'($urandom_range(0, 60));
            END_ZERO: end_addr = '0;
            default:  end_addr = rand_addr();
        endcase
        len_word = rand_addr();
        len_word[LEN_W-1:0] = len_val;
        program_scan(len_word, end_addr);
        load_fresh_pattern();
        len = tracker.active_length();
        send_restart(base);
        send_pattern_copy(1'b0);
        n = 0;
        while (n < words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                k = $urandom_range(0, 7);
                if (k == 0)
                    send_restart(wbps_pkg::END_RESET - ADDR_W'($urandom_range(0, 20)));
                else if (k == 1)
                    send_restart(rand_addr());
                else
                    send_restart(base + ADDR_W'($urandom_range(0, 40)));
                n++;
            end
            else if (pick < 16)
            begin
                k = $urandom_range(0, 1) ? $urandom_range(0, len - 1) : $urandom_range(0, 127);
                send_load(k, rand_byte(), $urandom_range(0, 3) == 0);
                n++;
            end
            else if (pick < 19)
            begin
                send_word(make_word(ACT_NONE));
                n++;
            end
            else if (pick < 55 && len <= 32)
            begin
                send_pattern_copy($urandom_range(0, 3) == 0);
                n += len;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                    send_byte($urandom_range(0, 1) ? tracker.pat_value[$urandom_range(0, len - 1)]
                                                   : rand_byte());
                n += k;
            end
        end
    endtask

    logic [LEN_W-1:0] phase_len [PHASES] = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd5, 8'd8,
                                            8'd4, 8'd255, 8'd16, 8'd128, 8'd7, 8'd2};
    end_mode_t phase_end [PHASES] = '{END_OPEN, END_NEAR, END_OPEN, END_RANDOM, END_NEAR,
                                      END_OPEN, END_ZERO, END_OPEN, END_NEAR, END_OPEN,
                                      END_OPEN, END_OPEN};

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: length 1, no end limit
        send_load(0, 8'hFF, 1'b0);
        send_restart('0);
        send_byte(8'hFF);                   // first match, single_match set
        send_byte(8'h00);
        send_load(127, 8'h00, 1'b1);
        send_word(make_word(ACT_NONE));
        send_restart(wbps_pkg::END_RESET - 1'b1);
        send_byte(8'hFF);                   // match at the top address below the end
        send_byte(8'hFF);                   // address now equals the end: dropped
        send_load(0, 8'h5A, 1'b1);
        send_restart(48'd5);
        send_byte(8'h00);                   // wildcard takes any byte

        program_scan('0, 48'd6);            // zero length behaves as one
        send_restart(48'd5);
        send_byte(8'h33);
        send_byte(8'h33);                   // reaches the end address: dropped

        program_scan(48'd3, wbps_pkg::END_RESET);
        send_load(0, 8'hAB, 1'b0);
        send_load(1, 8'h00, 1'b1);
        send_load(2, 8'h00, 1'b0);
        send_restart(48'd100);
        send_byte(8'hAB);
        send_byte(8'h00);                   // window not yet full
        send_byte(8'h00);
        send_byte(8'hAB);
        send_byte(8'h11);
        send_restart(48'd200);              // a match must not straddle regions
        send_byte(8'h00);

        for (int p = 0; p < PHASES; p++)
            run_phase(phase_len[p], phase_end[p], (phase_len[p] > 32) ? 8 : 12);

        settle();
        $display("%0d words sent, %0d results checked, %0d matches predicted",
                 words_sent, tracker.checked, tracker.found);
        $display("pattern lengths 0 to 255 over %0d phases, end limits, region restarts",
                 PHASES);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/wbps_pkg.sv
design/wbps_cell.sv
design/wbps_reduce.sv
design/wildcard_byte_pattern_scanner.sv
tb/sv/testbench.sv
